// File: design/fqd_pkg.sv
// Shared types and constants for the queue with delete-by-value.
package fqd_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_DEL = 2'd2
  } op_e;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic enq;  // write the tail cell
    logic deq;  // every cell takes its right neighbour
    logic del;  // cells at or after the first match take their right neighbour
  } cell_ctl_t;

endpackage

// File: design/fqd_if.sv
// Request and response channel interfaces.
interface fqd_req_if;
  logic                       valid;
  logic                       ready;
  logic [fqd_pkg::FUNC_W-1:0] func;
  logic [fqd_pkg::VAL_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface fqd_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [fqd_pkg::VAL_W-1:0] taken_value;
  logic [fqd_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, output status, output taken_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input taken_value, input occupancy,
                  output ready);
endinterface

// File: design/fqd_cell.sv
// One storage cell of the queue: holds a tag, compares, shifts towards the head.
module fqd_cell #(
  parameter int unsigned TAG_W = 32
) (
  input  logic               clk_i,
  input  fqd_pkg::cell_ctl_t ctl_i,
  input  logic [TAG_W-1:0]   tag_i,
  input  logic               occ_i,     // cell holds a live entry
  input  logic               tail_i,    // first free position
  input  logic               found_i,   // match seen nearer the head
  input  logic [TAG_W-1:0]   next_i,    // right neighbour's entry
  output logic [TAG_W-1:0]   entry_o,
  output logic               found_o
);

  logic [TAG_W-1:0] entry_q;
  logic [TAG_W-1:0] entry_d;
  logic             match;
  logic             shift;

  assign match   = ctl_i.del && occ_i && (entry_q == tag_i);
  assign found_o = found_i || match;
  assign shift   = ctl_i.deq || (ctl_i.del && found_o);

  always_comb begin
    entry_d = entry_q;
    if (shift) begin
      entry_d = next_i;
    end else if (ctl_i.enq && tail_i) begin
      entry_d = tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: design/fifo_queue_with_delete_top.sv
// Top level of the queue with enqueue, dequeue and delete-first-match.
//
//  channel | dir | fields                              | handshake
//  --------+-----+-------------------------------------+------------
//  req_i   | in  | func[1:0], value[31:0]              | valid/ready
//  rsp_o   | out | status, taken_value[31:0], occ[4:0] | valid/ready
//
// One request per cycle: a request is resolved across the cell row in the
// cycle it is taken, and its response word sits in the output register
// from the next cycle. The delete search ripples through DEPTH cells.
// Reset clears the occupancy count and the output valid; cell contents
// are left as they are and only read below the count.
// A stalled response holds req_i.ready low until the word is taken.
module fifo_queue_with_delete_top #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fqd_req_if.sink   req_i,
  fqd_rsp_if.source rsp_o
);

  localparam int unsigned VW_OUT = fqd_pkg::VAL_W;
  localparam int unsigned OCC_OUT = fqd_pkg::OCC_W;
  // Tags are taken in their low VALUE_WIDTH bits, never wider than the port
  localparam int unsigned TAG_W = (VALUE_WIDTH < VW_OUT) ? VALUE_WIDTH : VW_OUT;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count_q, count_d;
  logic               rsp_valid_q;
  logic               status_q, status_d;
  logic [VW_OUT-1:0]  taken_q, taken_d;
  logic [OCC_OUT-1:0] occ_q;

  logic               accept;
  logic [TAG_W-1:0]   tag;
  logic               tag_nz;
  logic               full;
  logic               empty;
  fqd_pkg::cell_ctl_t ctl;

  logic [TAG_W-1:0]   entry_w [DEPTH];
  logic [DEPTH:0]     found_w;

  // Output register frees up as soon as its word is taken
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign tag    = TAG_W'(req_i.value);
  assign tag_nz = (tag != '0);
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);

  // Decode into the command seen by every cell
  always_comb begin
    ctl = '0;
    if (accept) begin
      unique case (req_i.func)
        fqd_pkg::OP_ENQ: ctl.enq = tag_nz && !full;
        fqd_pkg::OP_DEQ: ctl.deq = !empty;
        fqd_pkg::OP_DEL: ctl.del = tag_nz;
        default:         ctl     = '0;
      endcase
    end
  end

  // Cell row; cell 0 is the head, the last cell refills from itself
  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TAG_W-1:0] next;
    if (i == DEPTH - 1) begin : g_last
      assign next = entry_w[i];
    end else begin : g_mid
      assign next = entry_w[i+1];
    end

    fqd_cell #(
      .TAG_W(TAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .tag_i   (tag),
      .occ_i   (CW'(i) < count_q),
      .tail_i  (CW'(i) == count_q),
      .found_i (found_w[i]),
      .next_i  (next),
      .entry_o (entry_w[i]),
      .found_o (found_w[i+1])
    );
  end

  // Count update and response word
  always_comb begin
    count_d  = count_q;
    status_d = 1'b1;
    taken_d  = '0;
    if (ctl.enq) begin
      count_d  = count_q + CW'(1);
      status_d = 1'b0;
    end else if (ctl.deq) begin
      count_d  = count_q - CW'(1);
      status_d = 1'b0;
      taken_d  = VW_OUT'(entry_w[0]);
    end else if (ctl.del && found_w[DEPTH]) begin
      count_d  = count_q - CW'(1);
      status_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      taken_q  <= taken_d;
      occ_q    <= OCC_OUT'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.taken_value = taken_q;
  assign rsp_o.occupancy   = occ_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy count beyond depth");

  a_err_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && status_q |-> taken_q == '0)
    else $error("error response carries a value");

  a_occ_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> occ_q == OCC_OUT'(count_q))
    else $error("reported occupancy differs from count");

  a_accept_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted request produced no response");

endmodule

// File: tb/sv/fqd_queue_checker.sv
// Checker for the queue with delete-by-value: predicts each response word and compares it.
module fqd_queue_checker
  import fqd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fqd_req_if          req_i,
  fqd_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] taken_value;
    logic [OCC_W-1:0] occupancy;
  } rsp_word_t;

  // Shadow copy of the queue, head at index 0
  logic [VAL_W-1:0] held_tags[$];
  rsp_word_t        expected_words[$];

  // Applies one request to the shadow queue and returns the word it should produce
  function automatic rsp_word_t apply_request(input logic [FUNC_W-1:0] func,
                                              input logic [VAL_W-1:0]  value);
    rsp_word_t word;
    int        hit;
    word.status      = 1'b1;
    word.taken_value = '0;
    hit              = -1;
    case (func)
      OP_ENQ: begin
        if (value != '0 && held_tags.size() < DEPTH) begin
          held_tags.push_back(value);
          word.status = 1'b0;
        end
      end
      OP_DEQ: begin
        if (held_tags.size() > 0) begin
          word.taken_value = held_tags.pop_front();
          word.status      = 1'b0;
        end
      end
      OP_DEL: begin
        if (value != '0) begin
          for (int i = 0; i < held_tags.size() && hit < 0; i++)
            if (held_tags[i] == value) hit = i;
          if (hit >= 0) begin
            held_tags.delete(hit);
            word.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    word.occupancy = OCC_W'(held_tags.size());
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : check_words
    int unsigned errs;
    rsp_word_t   want;
    errs = 0;
    if (!rst_ni) begin
      held_tags.delete();
      expected_words.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_words.size() == 0) begin
          $error("response word with none expected: status %0h taken_value %0h occupancy %0d",
                 rsp_i.status, rsp_i.taken_value, rsp_i.occupancy);
          errs++;
        end else begin
          want = expected_words.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0h actual %0h", want.status, rsp_i.status);
            errs++;
          end
          if (rsp_i.taken_value !== want.taken_value) begin
            $error("taken_value: expected %0h actual %0h", want.taken_value, rsp_i.taken_value);
            errs++;
          end
          if (rsp_i.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d actual %0d", want.occupancy, rsp_i.occupancy);
            errs++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_words.push_back(apply_request(req_i.func, req_i.value));
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_words.size();
    end
  end

endmodule

// File: tb/sv/tb_fifo_queue_with_delete_top.sv
// Testbench top for the queue with delete-by-value: stimulus, back-pressure and verdict.
module tb_fifo_queue_with_delete_top;
  import fqd_pkg::*;

  localparam int unsigned         DEPTH          = 16;
  localparam logic [FUNC_W-1:0]   OP_BAD         = 2'd3;  // unused code, must be refused
  localparam int unsigned         RANDOM_WORDS   = 450;
  localparam int unsigned         WATCHDOG_LIMIT = 1000;  // cycles with no word moving

  logic        clk;
  logic        rst_n;
  logic        calm;           // no idling on either side while set
  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned quiet_cycles;

  fqd_req_if req_bus ();
  fqd_rsp_if rsp_bus ();

  fifo_queue_with_delete_top #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VAL_W)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  fqd_queue_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_bus),
    .rsp_i       (rsp_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Response side: stalls roughly a third of the cycles, never during the calm stretch.
  // Driven on the falling edge so the block sees a settled ready at the rising edge.
  always @(negedge clk) begin
    rsp_bus.ready <= calm || ($urandom_range(99) >= 34);
  end

  // Watchdog: any cycle in which neither channel moves a word counts towards the limit.
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_fifo_queue_with_delete_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request word, with an optional random gap before it, and returns at the
  // falling edge after it has been taken. valid stays high into the next word when no
  // gap follows, so it is never dropped and raised in one step.
  // Each gap cycle is drawn on its own, so the sender idles about a third of the time.
  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [VAL_W-1:0] value);
    while (!calm && $urandom_range(99) < 34) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.func  <= func;
    req_bus.value <= value;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  // Holds the request side off until every response word has been taken
  task automatic wait_until_drained();
    req_bus.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  // Tags mostly from a small pool so deletes find matches and duplicates build up;
  // now and then a wide random tag or the null tag.
  function automatic logic [VAL_W-1:0] pick_tag();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 15) return VAL_W'($urandom());
    return VAL_W'($urandom_range(6, 1));
  endfunction

  initial begin : stimulus
    logic [FUNC_W-1:0] func;
    logic [VAL_W-1:0]  value;
    int unsigned       roll;
    int unsigned       enq_share;

    rst_n         = 1'b0;
    calm          = 1'b0;
    quiet_cycles  = 0;
    req_bus.valid = 1'b0;
    req_bus.func  = OP_ENQ;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;
    enq_share     = 50;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-queue refusals, null tag and the unused code first
    send_word(OP_DEQ, 32'h0000_0000);
    send_word(OP_DEL, 32'h0000_0005);
    send_word(OP_ENQ, 32'h0000_0000);
    send_word(OP_BAD, 32'h1234_5678);

    // Fill to the brim: extreme tags at the head, a duplicate pair in the middle
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       value = 32'hFFFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = 32'h0000_0001;
        5, 9:    value = 32'h0000_00A5;
        default: value = 32'h0000_0100 + i;
      endcase
      send_word(OP_ENQ, value);
    end
    send_word(OP_ENQ, 32'h0000_0077);                 // full, refused
    send_word(OP_DEL, 32'h0000_0000);                 // null tag on delete
    send_word(OP_DEL, 32'h0000_0007);                 // no match
    send_word(OP_DEL, 32'hFFFF_FFFF);                 // head match
    send_word(OP_DEL, 32'h0000_0100 + DEPTH - 1);     // tail match, just shortens
    send_word(OP_DEL, 32'h0000_00A5);                 // first of the duplicates only
    send_word(OP_DEQ, 32'h5A5A_5A5A);                 // value ignored on dequeue

    // Let everything come back before the random part
    wait_until_drained();

    // Random part: phases lean towards filling or emptying so both ends get visited
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) enq_share = $urandom_range(80, 20);
      calm = (n >= 150 && n < 230);
      if (n == 300) wait_until_drained();
      roll = $urandom_range(99);
      if (roll < 3)
        func = OP_BAD;
      else if (roll < enq_share)
        func = OP_ENQ;
      else if (roll < enq_share + (100 - enq_share) / 2)
        func = OP_DEQ;
      else
        func = OP_DEL;
      value = (func == OP_DEQ) ? VAL_W'($urandom()) : pick_tag();
      send_word(func, value);
    end
    calm = 1'b0;

    // Drain, then a few spare cycles for any stray word
    wait_until_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_fifo_queue_with_delete_top passed");
    end else begin
      $display("tb_fifo_queue_with_delete_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fqd_pkg.sv
design/fqd_if.sv
design/fqd_cell.sv
design/fifo_queue_with_delete_top.sv
tb/sv/fqd_queue_checker.sv
tb/sv/tb_fifo_queue_with_delete_top.sv
